FILE: rtl/urihr_pkg.sv
// Shared types, constants and helpers for the URI id hash router.
package urihr_pkg;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int CNT_CFG_W = 7;
    localparam int IDX_W = 6;
    localparam int HASH_W = 32;
    localparam int STATUS_W = 2;

    // Largest usable backend count; larger writes saturate
    localparam int MAX_BACKENDS = 64;

    // Reflected CRC-32
    localparam logic [HASH_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [HASH_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

    // Step counts of the shared unit
    localparam int CRC_STEPS = BYTE_W;
    localparam int DIV_STEPS = HASH_W;
    localparam int STEP_W = $clog2(DIV_STEPS);

    // Path prefix "/api/" and segment separator
    localparam int PREFIX_LEN = 5;
    localparam int POS_W = 3;
    localparam logic [BYTE_W-1:0] SEP_CHAR = 8'h2F;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CRC,
        ST_EVAL,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        PH_PREFIX,
        PH_OWNER,
        PH_APP,
        PH_ID,
        PH_FAILED
    } t_phase;

    typedef enum logic [STATUS_W-1:0] {
        STS_ROUTED     = 2'd0,
        STS_METHOD     = 2'd1,
        STS_BAD_REQ    = 2'd2,
        STS_NO_BACKEND = 2'd3
    } t_status;

    typedef enum logic {
        OP_CRC,
        OP_DIV
    } t_alu_op;

    // Control into the shared shift unit
    typedef struct packed {
        t_alu_op op;
        logic    data_bit;
    } t_alu_ctl;

    // One finished routing result
    typedef struct packed {
        t_status           status;
        logic [IDX_W-1:0]  index;
        logic [HASH_W-1:0] hash;
    } t_result;

    // Expected prefix character at a given position
    function automatic logic [BYTE_W-1:0] prefix_char(input logic [POS_W-1:0] pos);
        logic [BYTE_W-1:0] c;
        case (pos)
            3'd0:    c = 8'h2F; // '/'
            3'd1:    c = 8'h61; // 'a'
            3'd2:    c = 8'h70; // 'p'
            3'd3:    c = 8'h69; // 'i'
            3'd4:    c = 8'h2F; // '/'
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/urihr_alu.sv
// Shared shift unit: one CRC-32 bit step or one restoring-division step.
module urihr_alu (
    input  urihr_pkg::t_alu_ctl                   i_ctl,
    input  logic [urihr_pkg::HASH_W-1:0]          i_acc,
    input  logic [urihr_pkg::CNT_CFG_W-1:0]       i_rem,
    input  logic [urihr_pkg::CNT_CFG_W-1:0]       i_div,
    output logic [urihr_pkg::HASH_W-1:0]          o_acc,
    output logic [urihr_pkg::CNT_CFG_W-1:0]       o_rem
);
    import urihr_pkg::*;

    logic                 w_fb;
    logic [CNT_CFG_W:0]   w_trial;
    logic [CNT_CFG_W:0]   w_diff;

    assign w_fb    = i_acc[0] ^ i_ctl.data_bit;
    assign w_trial = {i_rem, i_acc[HASH_W-1]};
    assign w_diff  = w_trial - {1'b0, i_div};

    // CRC: shift right, fold in the polynomial on feedback
    // DIV: bring down the next dividend bit, subtract if it fits
    always_comb begin
        case (i_ctl.op)
            OP_CRC: begin
                o_acc = {1'b0, i_acc[HASH_W-1:1]} ^ (w_fb ? CRC_POLY : '0);
                o_rem = i_rem;
            end
            OP_DIV: begin
                o_acc = {i_acc[HASH_W-2:0], 1'b0};
                if (w_trial >= {1'b0, i_div}) begin
                    o_rem = w_diff[CNT_CFG_W-1:0];
                end else begin
                    o_rem = w_trial[CNT_CFG_W-1:0];
                end
            end
            default: begin
                o_acc = i_acc;
                o_rem = i_rem;
            end
        endcase
    end

endmodule

FILE: rtl/urihr_ctrl.sv
// Path parser and sequencer driving the shared shift unit.
module urihr_ctrl (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_req_valid,
    output logic                                  o_req_ready,
    input  logic [urihr_pkg::BYTE_W-1:0]          i_path_byte,
    input  logic                                  i_last_byte,
    input  logic                                  i_method_allowed,
    input  logic [urihr_pkg::CNT_CFG_W-1:0]       i_backend_count,
    input  logic                                  i_slot_free,
    output logic                                  o_res_load,
    output urihr_pkg::t_result                    o_res
);
    import urihr_pkg::*;

    t_state                 r_state, n_state;
    t_phase                 r_phase, n_phase;
    logic [POS_W-1:0]       r_pos, n_pos;
    logic [HASH_W-1:0]      r_acc, n_acc;
    logic                   r_id_seen, n_id_seen;
    logic [BYTE_W-1:0]      r_byte, n_byte;
    logic                   r_last, n_last;
    logic                   r_allowed, n_allowed;
    logic [STEP_W-1:0]      r_cnt, n_cnt;
    logic [CNT_CFG_W-1:0]   r_rem, n_rem;
    logic [HASH_W-1:0]      r_hash, n_hash;
    t_status                r_status, n_status;

    t_alu_ctl               w_alu_ctl;
    logic [HASH_W-1:0]      w_alu_acc;
    logic [CNT_CFG_W-1:0]   w_alu_rem;
    logic                   w_accept;
    t_status                w_eval_status;

    assign w_accept = i_req_valid && o_req_ready;

    // Shared unit
    urihr_alu u_alu (
        .i_ctl (w_alu_ctl),
        .i_acc (r_acc),
        .i_rem (r_rem),
        .i_div (i_backend_count),
        .o_acc (w_alu_acc),
        .o_rem (w_alu_rem)
    );

    // Final verdict, by priority
    always_comb begin
        if (!r_allowed) begin
            w_eval_status = STS_METHOD;
        end else if (r_phase != PH_ID || !r_id_seen) begin
            w_eval_status = STS_BAD_REQ;
        end else if (i_backend_count == '0) begin
            w_eval_status = STS_NO_BACKEND;
        end else begin
            w_eval_status = STS_ROUTED;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (r_phase == PH_ID) begin
                        n_state = ST_CRC;
                    end else if (i_last_byte) begin
                        n_state = ST_EVAL;
                    end
                end
            end
            ST_CRC: begin
                if (r_cnt == STEP_W'(CRC_STEPS - 1)) begin
                    n_state = r_last ? ST_EVAL : ST_IDLE;
                end
            end
            ST_EVAL: begin
                n_state = (w_eval_status == STS_ROUTED) ? ST_DIV : ST_DONE;
            end
            ST_DIV: begin
                if (r_cnt == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_req_ready        = (r_state == ST_IDLE);
        o_res_load         = (r_state == ST_DONE) && i_slot_free;
        w_alu_ctl.op       = (r_state == ST_DIV) ? OP_DIV : OP_CRC;
        w_alu_ctl.data_bit = r_byte[0];
        o_res.status       = r_status;
        o_res.index        = (r_status == STS_ROUTED) ? r_rem[IDX_W-1:0] : '0;
        o_res.hash         = r_hash;
    end

    // Datapath next values
    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_acc     = r_acc;
        n_id_seen = r_id_seen;
        n_byte    = r_byte;
        n_last    = r_last;
        n_allowed = r_allowed;
        n_cnt     = r_cnt;
        n_rem     = r_rem;
        n_hash    = r_hash;
        n_status  = r_status;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_byte    = i_path_byte;
                    n_last    = i_last_byte;
                    n_allowed = i_method_allowed;
                    n_cnt     = '0;
                    case (r_phase)
                        PH_PREFIX: begin
                            if (i_path_byte == prefix_char(r_pos)) begin
                                n_pos = r_pos + 1'b1;
                                if (r_pos == POS_W'(PREFIX_LEN - 1)) begin
                                    n_phase = PH_OWNER;
                                end
                            end else begin
                                n_phase = PH_FAILED;
                            end
                        end
                        PH_OWNER: begin
                            if (i_path_byte == SEP_CHAR) begin
                                n_phase = PH_APP;
                            end
                        end
                        PH_APP: begin
                            if (i_path_byte == SEP_CHAR) begin
                                n_phase = PH_ID;
                            end
                        end
                        PH_ID:   n_id_seen = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_CRC: begin
                n_acc  = w_alu_acc;
                n_byte = {1'b0, r_byte[BYTE_W-1:1]};
                n_cnt  = r_cnt + 1'b1;
            end
            ST_EVAL: begin
                n_status = w_eval_status;
                if (w_eval_status == STS_ROUTED || w_eval_status == STS_NO_BACKEND) begin
                    n_hash = ~r_acc;
                end else begin
                    n_hash = '0;
                end
                n_acc = ~r_acc;
                n_rem = '0;
                n_cnt = '0;
            end
            ST_DIV: begin
                n_acc = w_alu_acc;
                n_rem = w_alu_rem;
                n_cnt = r_cnt + 1'b1;
            end
            ST_DONE: begin
                // parser back to start for the next request
                if (i_slot_free) begin
                    n_phase   = PH_PREFIX;
                    n_pos     = '0;
                    n_acc     = CRC_INIT;
                    n_id_seen = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_phase   <= PH_PREFIX;
            r_pos     <= '0;
            r_acc     <= CRC_INIT;
            r_id_seen <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_acc     <= n_acc;
            r_id_seen <= n_id_seen;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_byte    <= n_byte;
        r_last    <= n_last;
        r_allowed <= n_allowed;
        r_cnt     <= n_cnt;
        r_rem     <= n_rem;
        r_hash    <= n_hash;
        r_status  <= n_status;
    end

`ifndef ASSERT_OFF
    // A byte's CRC pass ends in the verdict or back at idle
    a_crc_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CRC && r_cnt == STEP_W'(CRC_STEPS - 1))
            |=> (r_state == ST_EVAL || r_state == ST_IDLE))
        else $error("CRC pass did not finish after eight steps");

    // Remainder stays below the divisor throughout the division
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < i_backend_count))
        else $error("division remainder out of range");

    // Parser is back at its start after a result leaves
    a_parser_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_load |=> (r_phase == PH_PREFIX && r_pos == '0
                        && r_acc == CRC_INIT && !r_id_seen))
        else $error("parser not cleared after result");

    // Rejected requests carry no hash
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_load && (o_res.status == STS_METHOD || o_res.status == STS_BAD_REQ))
            |-> (o_res.hash == '0 && o_res.index == '0))
        else $error("rejected request with non-zero hash or index");
`endif

endmodule

FILE: rtl/uri_id_hash_router_core.sv
// Top level of the URI id hash router: config register, result register, sequencer.
//
//  channel   direction  handshake                   payload
//  request   in         i_req_valid / o_req_ready   i_path_byte, i_last_byte, i_method_allowed
//  response  out        o_rsp_valid / i_rsp_ready   o_route_status, o_backend_index, o_id_hash
//  config    in         i_cfg_we                    i_cfg_data (backend count)
//
// A prefix, owner or app-name byte is taken in the idle state; an id byte also runs
// eight bit steps of the shared CRC shift unit after it is accepted.
// The final byte adds the verdict and done states, plus 32 restoring-division steps on the same unit
// when the request is routed (backend index = hash modulo backend count).
// Reset is synchronous, active low; the parser then waits for the first byte.
// The finished result sits in the response register; the sequencer holds it back
// only while that register is still full and not being taken.
module uri_id_hash_router_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_req_valid,
    output logic                                  o_req_ready,
    input  logic [urihr_pkg::BYTE_W-1:0]          i_path_byte,
    input  logic                                  i_last_byte,
    input  logic                                  i_method_allowed,
    output logic                                  o_rsp_valid,
    input  logic                                  i_rsp_ready,
    output logic [urihr_pkg::STATUS_W-1:0]        o_route_status,
    output logic [urihr_pkg::IDX_W-1:0]           o_backend_index,
    output logic [urihr_pkg::HASH_W-1:0]          o_id_hash,
    input  logic                                  i_cfg_we,
    input  logic [urihr_pkg::CNT_CFG_W-1:0]       i_cfg_data
);
    import urihr_pkg::*;

    logic [CNT_CFG_W-1:0]  r_backend_count;
    logic [CNT_CFG_W-1:0]  n_backend_count;
    logic                  r_rsp_valid;
    t_result               r_rsp;
    logic                  w_slot_free;
    logic                  w_res_load;
    t_result               w_res;

    // Backend count, saturated on write
    always_comb begin
        if (32'(i_cfg_data) > 32'(MAX_BACKENDS)) begin
            n_backend_count = CNT_CFG_W'(MAX_BACKENDS);
        end else begin
            n_backend_count = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_backend_count <= '0;
        end else if (i_cfg_we) begin
            r_backend_count <= n_backend_count;
        end
    end

    assign w_slot_free = !r_rsp_valid || i_rsp_ready;

    urihr_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (i_req_valid),
        .o_req_ready      (o_req_ready),
        .i_path_byte      (i_path_byte),
        .i_last_byte      (i_last_byte),
        .i_method_allowed (i_method_allowed),
        .i_backend_count  (r_backend_count),
        .i_slot_free      (w_slot_free),
        .o_res_load       (w_res_load),
        .o_res            (w_res)
    );

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (w_res_load) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_rsp <= w_res;
        end
    end

    assign o_rsp_valid     = r_rsp_valid;
    assign o_route_status  = r_rsp.status;
    assign o_backend_index = r_rsp.index;
    assign o_id_hash       = r_rsp.hash;

endmodule

FILE: tb/sv/uri_id_hash_router_core_test.sv
// Self-checking testbench for the URI id hash router core: path requests in, route results checked.
module uri_id_hash_router_core_test;
    import urihr_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 60;   // longer than one id byte plus the final division
    localparam int LONG_HOLD = 400;
    localparam int BYTES_PER_PHASE = 135;
    localparam logic [BYTE_W-1:0] API_PREFIX [PREFIX_LEN] = '{8'h2F, 8'h61, 8'h70, 8'h69, 8'h2F};

    // Predictor and store of expected routes
    class route_checker;
        t_phase             phase;
        logic [POS_W-1:0]   prefix_pos;
        logic [HASH_W-1:0]  crc;
        bit                 id_seen;
        logic [CNT_CFG_W-1:0] backend_count;
        t_result            expected_routes[$];
        int                 mismatch_count;

        function new();
            backend_count = '0;
            mismatch_count = 0;
            clear_path();
        endfunction

        function void clear_path();
            phase = PH_PREFIX;
            prefix_pos = '0;
            crc = CRC_INIT;
            id_seen = 1'b0;
        endfunction

        function automatic logic [HASH_W-1:0] crc_step(logic [HASH_W-1:0] c,
                                                        logic [BYTE_W-1:0] b);
            c ^= {24'd0, b};
            for (int k = 0; k < 8; k++)
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            return c;
        endfunction

        // Walk the parser over one accepted request; the final byte yields a route
        function void note_request(logic [BYTE_W-1:0] b, bit last, bit allowed);
            t_result r;
            int unsigned count;
            logic [HASH_W-1:0] hash;
            case (phase)
                PH_PREFIX: begin
                    if (b == API_PREFIX[prefix_pos]) begin
                        prefix_pos++;
                        if (prefix_pos == PREFIX_LEN)
                            phase = PH_OWNER;
                    end else begin
                        phase = PH_FAILED;
                    end
                end
                PH_OWNER: if (b == SEP_CHAR) phase = PH_APP;
                PH_APP:   if (b == SEP_CHAR) phase = PH_ID;
                PH_ID: begin
                    crc = crc_step(crc, b);
                    id_seen = 1'b1;
                end
                default: ;
            endcase
            if (!last)
                return;
            count = (backend_count > MAX_BACKENDS) ? MAX_BACKENDS : backend_count;
            r = '0;
            // method check first, then path, then backend availability
            if (!allowed) begin
                r.status = STS_METHOD;
            end else if (phase != PH_ID || !id_seen) begin
                r.status = STS_BAD_REQ;
            end else begin
                hash = crc ^ 32'hFFFF_FFFF;
                r.hash = hash;
                if (count == 0) begin
                    r.status = STS_NO_BACKEND;
                end else begin
                    r.status = STS_ROUTED;
                    r.index = IDX_W'(hash % count);
                end
            end
            expected_routes.push_back(r);
            clear_path();
        endfunction

        function void check_route(logic [STATUS_W-1:0] st, logic [IDX_W-1:0] idx,
                                  logic [HASH_W-1:0] h);
            t_result e;
            if (expected_routes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("route with none expected: status %0d index %0d hash %h",
                             st, idx, h);
                return;
            end
            e = expected_routes.pop_front();
            if (st !== e.status || idx !== e.index || h !== e.hash) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("route mismatch: status %0d/%0d index %0d/%0d hash %h/%h (exp/got)",
                             e.status, st, e.index, idx, e.hash, h);
            end
        endfunction

        function int pending();
            return expected_routes.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_req_valid = 1'b0;
    logic                 o_req_ready;
    logic [BYTE_W-1:0]    i_path_byte = '0;
    logic                 i_last_byte = 1'b0;
    logic                 i_method_allowed = 1'b0;
    logic                 o_rsp_valid;
    logic                 i_rsp_ready = 1'b0;
    logic [STATUS_W-1:0]  o_route_status;
    logic [IDX_W-1:0]     o_backend_index;
    logic [HASH_W-1:0]    o_id_hash;
    logic                 i_cfg_we = 1'b0;
    logic [CNT_CFG_W-1:0] i_cfg_data = '0;

    route_checker   sb = new();
    logic [BYTE_W-1:0] path_bytes[$];
    int             burst_left = 0;
    int             bytes_sent = 0;
    int             phase_no = 0;

    uri_id_hash_router_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (i_req_valid),
        .o_req_ready      (o_req_ready),
        .i_path_byte      (i_path_byte),
        .i_last_byte      (i_last_byte),
        .i_method_allowed (i_method_allowed),
        .o_rsp_valid      (o_rsp_valid),
        .i_rsp_ready      (i_rsp_ready),
        .o_route_status   (o_route_status),
        .o_backend_index  (o_backend_index),
        .o_id_hash        (o_id_hash),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Cycle watchdog
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Response side: check results, stall in shifting modes plus one long hold
    initial begin : receiver
        int  mode;
        int  mode_left;
        int  hold_left;
        bit  long_hold_done;
        logic [7:0] stall_mask;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        long_hold_done = 1'b0;
        stall_mask = 8'hA5;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_rsp_valid && i_rsp_ready)
                sb.check_route(o_route_status, o_backend_index, o_id_hash);
            if (phase_no == 2 && !long_hold_done) begin
                hold_left = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 128);
                stall_mask = 8'($urandom);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_rsp_ready <= 1'b0;
            end else begin
                case (mode)
                    0:       i_rsp_ready <= 1'b1;
                    1:       i_rsp_ready <= 1'($urandom_range(0, 1));
                    2:       i_rsp_ready <= ($urandom_range(0, 3) == 0);
                    default: i_rsp_ready <= stall_mask[mode_left[2:0]];
                endcase
            end
        end
    end

    // Offer one request, in bursts with random gaps
    task automatic push_request(logic [BYTE_W-1:0] b, bit last, bit allowed);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_req_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_req_valid <= 1'b1;
        i_path_byte <= b;
        i_last_byte <= last;
        i_method_allowed <= allowed;
        do @(posedge i_clk); while (!o_req_ready);
        sb.note_request(b, last, allowed);
        burst_left--;
        bytes_sent++;
    endtask

    // Send the queued path; method flag is random on non-final bytes
    task automatic send_path(bit allowed);
        for (int i = 0; i < path_bytes.size(); i++) begin
            if (i == path_bytes.size() - 1)
                push_request(path_bytes[i], 1'b1, allowed);
            else
                push_request(path_bytes[i], 1'b0, 1'($urandom_range(0, 1)));
        end
        path_bytes.delete();
    endtask

    function automatic void append_text(string s);
        for (int i = 0; i < s.len(); i++)
            path_bytes.push_back(s[i]);
    endfunction

    function automatic logic [BYTE_W-1:0] non_sep_byte();
        logic [BYTE_W-1:0] b;
        do b = BYTE_W'($urandom); while (b == SEP_CHAR);
        return b;
    endfunction

    // Stop offering and wait until every expected route has come back
    task automatic wait_for_routes();
        i_req_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_backends(logic [CNT_CFG_W-1:0] count);
        i_cfg_we <= 1'b1;
        i_cfg_data <= count;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.backend_count = count;
    endtask

    // One random path: mostly well formed, some truncated or with a broken prefix, some noise
    task automatic random_path();
        int kind;
        int n;
        int pos;
        logic [BYTE_W-1:0] b;
        kind = $urandom_range(0, 99);
        if (kind >= 90) begin
            n = $urandom_range(1, 4);
            repeat (n) path_bytes.push_back(BYTE_W'($urandom));
        end else begin
            append_text("/api/");
            n = $urandom_range(0, 3);
            repeat (n) path_bytes.push_back(non_sep_byte());
            path_bytes.push_back(SEP_CHAR);
            n = $urandom_range(0, 3);
            repeat (n) path_bytes.push_back(non_sep_byte());
            path_bytes.push_back(SEP_CHAR);
            n = $urandom_range(1, 6);
            repeat (n) path_bytes.push_back(BYTE_W'($urandom));
            if (kind >= 80) begin
                pos = $urandom_range(0, PREFIX_LEN - 1);
                do b = BYTE_W'($urandom); while (b == path_bytes[pos]);
                path_bytes[pos] = b;
            end else if (kind >= 70) begin
                n = $urandom_range(1, path_bytes.size());
                while (path_bytes.size() > n)
                    void'(path_bytes.pop_back());
            end
        end
        send_path($urandom_range(0, 9) != 0);
    endtask

    initial begin : stimulus
        logic [CNT_CFG_W-1:0] counts[$];
        int target;
        counts = {7'd64, 7'd127, 7'd1, 7'd0, 7'd7, 7'd65, 7'd13, 7'd100, 7'd0};
        counts[counts.size() - 1] = CNT_CFG_W'($urandom);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed paths under the reset backend count of zero
        append_text("/api///");           // id empty after the second separator
        send_path(1'b1);
        append_text("/api///");
        path_bytes.push_back(8'hFF);      // one id byte, no backends yet
        send_path(1'b1);
        path_bytes.push_back(8'h00);      // method refused on a one-byte path
        send_path(1'b0);
        append_text("/X");                // prefix mismatch
        send_path(1'b1);
        append_text("/a");                // ends inside the prefix
        send_path(1'b1);
        wait_for_routes();

        // Random phases, one backend count each
        foreach (counts[i]) begin
            phase_no = i + 1;
            set_backends(counts[i]);
            target = bytes_sent + BYTES_PER_PHASE;
            while (bytes_sent < target)
                random_path();
            wait_for_routes();
        end

        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
